/* rtl/bss_pkg.sv */
// bounded string set: shared widths, operation codes and register indexes
// used by the bounded_string_set top level; no dependencies
`default_nettype none

package bss_pkg;

  // defaults for the top-level parameters
  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_BYTES_DEF = 8;

  // field widths
  localparam int KIND_W  = 3;
  localparam int CHARS_W = 64;
  localparam int LEN_W   = 4;
  localparam int SLOT_W  = 6;
  localparam int OCC_W   = 7;
  localparam int CAP_W   = 7;
  localparam int ISZ_W   = 4;

  // stream and configuration widths
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 88;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  // register reset values
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic [ISZ_W-1:0] ISZ_RESET = 4'd9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_SIZE = 1'b1;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_FETCH  = 3'd2,
    KIND_GET    = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

endpackage

`default_nettype wire

/* rtl/bounded_string_set.sv */
// bounded string set: fixed-capacity table of unique short keys with a
// linear-search sequencer over one single-port-read entry memory; uses bss_pkg
//
//  channel  | direction | handshake                      | payload
//  s_axis   | in        | s_axis_tvalid_i/s_axis_tready_o | tdata: key, length, slot; tuser: kind
//  m_axis   | out       | m_axis_tvalid_o/m_axis_tready_i | tdata: result fields
//  cfg      | in        | cfg_valid_i/cfg_ready_o         | cfg_index_i, cfg_data_i
//
// one item at a time; append and fetch read one stored entry per cycle from
// the entry memory over the occupied slots, remove moves the last entry into
// the freed slot, get reads the addressed entry, clear and failed checks go
// straight to the result; reset empties the table and loads capacity 64 and item size 9
// a result waits in the output register while the next item is accepted
`default_nettype none

module bounded_string_set #(
  parameter int CAPACITY  = bss_pkg::CAPACITY_DEF,
  parameter int KEY_BYTES = bss_pkg::KEY_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input items
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // key_chars[63:0], key_length[67:64], slot[73:68], zero pad
  input  wire logic [bss_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // kind[2:0]
  input  wire logic [bss_pkg::KIND_W-1:0]      s_axis_tuser_i,
  // result items
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // ok[0], found_slot[6:1], entry_chars[70:7], entry_length[74:71],
  // occupancy[81:75], is_full[82], is_empty[83], zero pad
  output logic [bss_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // configuration writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bss_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bss_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bss_pkg::*;

  localparam int KW = 8 * KEY_BYTES;
  localparam int EW = KW + LEN_W;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);
  localparam logic [LEN_W-1:0] KEY_BYTES_L = LEN_W'(KEY_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_MOVE,
    ST_READ_OUT,
    ST_RESULT
  } state_e;

  state_e                state_q;
  kind_e                 kind_q;
  logic [KW-1:0]         key_q;
  logic [LEN_W-1:0]      len_q;
  logic                  key_ok_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [CW-1:0]         count_q;
  logic [CAP_W-1:0]      cap_q;
  logic [ISZ_W-1:0]      isz_q;
  logic [CW-1:0]         issue_q;
  logic                  rvld_q;
  logic [AW-1:0]         ridx_q;
  logic                  ok_q;
  logic [SLOT_W-1:0]     fslot_q;
  logic [CHARS_W-1:0]    echars_q;
  logic [LEN_W-1:0]      elen_q;
  logic                  m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  // entry memory: key characters in the low bits, length on top
  logic [EW-1:0]         mem [CAPACITY];
  logic [EW-1:0]         rdata_q;
  logic [AW-1:0]         raddr;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [EW-1:0]         wdata;

  // input fields
  logic [CHARS_W-1:0]    in_chars;
  logic [LEN_W-1:0]      in_len;
  logic [SLOT_W-1:0]     in_slot;
  logic [KW-1:0]         norm_key;
  logic [LEN_W-1:0]      norm_len;
  logic                  alive;

  // derived compares
  logic [XW-1:0]         count_x;
  logic [XW-1:0]         slot_x;
  logic [XW-1:0]         cap_x;
  logic [XW-1:0]         effcap_x;
  logic                  full;
  logic                  slot_in_range;
  logic                  slot_is_last;
  logic [CW-1:0]         last;
  logic                  append_ok;
  logic                  hit;
  logic                  scan_end;

  assign in_chars = s_axis_tdata_i[63:0];
  assign in_len   = s_axis_tdata_i[67:64];
  assign in_slot  = s_axis_tdata_i[73:68];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // key normalization: characters before the first zero byte within the length
  always_comb begin
    norm_key = '0;
    norm_len = '0;
    alive    = 1'b1;
    for (int i = 0; i < KEY_BYTES; i++) begin
      alive = alive && (LEN_W'(i) < in_len) && (in_chars[8*i +: 8] != 8'h00);
      if (alive) begin
        norm_key[8*i +: 8] = in_chars[8*i +: 8];
        norm_len           = norm_len + 4'd1;
      end
    end
  end

  // occupancy and range checks
  assign count_x       = XW'(count_q);
  assign slot_x        = XW'(slot_q);
  assign cap_x         = XW'(cap_q);
  assign effcap_x      = (cap_x > CAP_X) ? CAP_X : cap_x;
  assign full          = (count_x >= effcap_x);
  assign last          = count_q - CW'(1);
  assign slot_in_range = (slot_x < count_x);
  assign slot_is_last  = (slot_x == XW'(last));
  assign append_ok     = key_ok_q && (len_q != '0) &&
                         ({1'b0, len_q} + 5'd1 <= {1'b0, isz_q}) && !full;

  // scan compare on the entry read in the previous cycle
  assign hit      = rvld_q && (rdata_q[KW-1:0] == key_q) && (rdata_q[EW-1:KW] == len_q);
  assign scan_end = (issue_q >= count_q);

  // memory address and write control
  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = slot_x[AW-1:0];
    wdata = rdata_q;
    unique case (state_q)
      ST_DECODE: begin
        if (kind_q == KIND_REMOVE) begin
          raddr = last[AW-1:0];
        end else begin
          raddr = slot_x[AW-1:0];
        end
      end
      ST_SCAN: begin
        raddr = issue_q[AW-1:0];
        if (!hit && scan_end && kind_q == KIND_APPEND) begin
          we    = 1'b1;
          waddr = count_q[AW-1:0];
          wdata = {len_q, key_q};
        end
      end
      ST_MOVE: begin
        we = 1'b1;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      isz_q <= ISZ_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CAPACITY:  cap_q <= cfg_data_i;
        CFG_ITEM_SIZE: isz_q <= cfg_data_i[ISZ_W-1:0];
        default:       cap_q <= cap_q;
      endcase
    end
  end

  // sequencer, table count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rvld_q    <= 1'b0;
      m_valid_q <= 1'b0;
      kind_q    <= KIND_APPEND;
      key_q     <= '0;
      len_q     <= '0;
      key_ok_q  <= 1'b0;
      slot_q    <= '0;
      issue_q   <= '0;
      ridx_q    <= '0;
      ok_q      <= 1'b0;
      fslot_q   <= '0;
      echars_q  <= '0;
      elen_q    <= '0;
      m_data_q  <= '0;
    end else begin
      // result taken while no new one is loaded
      if (m_valid_q && m_axis_tready_i && state_q != ST_RESULT) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        // take a transaction and normalize its key
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            kind_q   <= kind_e'(s_axis_tuser_i);
            key_q    <= norm_key;
            len_q    <= norm_len;
            key_ok_q <= (in_len <= KEY_BYTES_L);
            slot_q   <= in_slot;
            state_q  <= ST_DECODE;
          end
        end
        // checks and dispatch
        ST_DECODE: begin
          fslot_q  <= '0;
          echars_q <= '0;
          elen_q   <= '0;
          issue_q  <= '0;
          rvld_q   <= 1'b0;
          unique case (kind_q)
            KIND_APPEND: begin
              ok_q <= 1'b0;
              if (append_ok) begin
                state_q <= ST_SCAN;
              end else begin
                state_q <= ST_RESULT;
              end
            end
            KIND_FETCH: begin
              ok_q <= 1'b0;
              if (key_ok_q) begin
                state_q <= ST_SCAN;
              end else begin
                state_q <= ST_RESULT;
              end
            end
            KIND_REMOVE: begin
              ok_q <= slot_in_range && slot_is_last;
              if (slot_in_range && !slot_is_last) begin
                state_q <= ST_MOVE;
              end else begin
                state_q <= ST_RESULT;
              end
              if (slot_in_range && slot_is_last) begin
                count_q <= last;
              end
            end
            KIND_GET: begin
              ok_q <= 1'b0;
              if (slot_in_range) begin
                state_q <= ST_READ_OUT;
              end else begin
                state_q <= ST_RESULT;
              end
            end
            KIND_CLEAR: begin
              count_q <= '0;
              ok_q    <= 1'b1;
              state_q <= ST_RESULT;
            end
            default: begin
              ok_q    <= 1'b0;
              state_q <= ST_RESULT;
            end
          endcase
        end
        // linear search, one entry read per cycle
        ST_SCAN: begin
          if (hit) begin
            rvld_q  <= 1'b0;
            state_q <= ST_RESULT;
            if (kind_q == KIND_FETCH) begin
              ok_q    <= 1'b1;
              fslot_q <= SLOT_W'(ridx_q);
            end
          end else if (scan_end) begin
            rvld_q  <= 1'b0;
            state_q <= ST_RESULT;
            if (kind_q == KIND_APPEND) begin
              count_q <= count_q + CW'(1);
              ok_q    <= 1'b1;
            end
          end else begin
            rvld_q  <= 1'b1;
            ridx_q  <= issue_q[AW-1:0];
            issue_q <= issue_q + CW'(1);
          end
        end
        // last entry moved into the freed slot
        ST_MOVE: begin
          count_q <= last;
          ok_q    <= 1'b1;
          state_q <= ST_RESULT;
        end
        // stored entry returned
        ST_READ_OUT: begin
          ok_q     <= 1'b1;
          echars_q <= CHARS_W'(rdata_q[KW-1:0]);
          elen_q   <= rdata_q[EW-1:KW];
          state_q  <= ST_RESULT;
        end
        // load the output register once it is free
        ST_RESULT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {4'd0, (count_q == '0), full, OCC_W'(count_q), elen_q,
                          echars_q, fslot_q, ok_q};
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* test/tb_top.sv */
// testbench for bounded_string_set: drives key-table operations over the input
// stream, mirrors the table in a scoreboard class and checks every result item
// depends on bss_pkg and the bounded_string_set rtl
`timescale 1ns / 1ps

module tb_top;
  import bss_pkg::*;

  localparam int          DEPTH      = CAPACITY_DEF;
  localparam int          NAME_BYTES = KEY_BYTES_DEF;
  localparam int          KIND_CODES = 8;
  localparam int unsigned LIMIT      = 1_500_000;
  localparam int          TAIL       = 80;

  // one input item, fields as the block sees them
  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [CHARS_W-1:0] chars;
    logic [LEN_W-1:0]   klen;
    logic [SLOT_W-1:0]  slot;
  } op_t;

  // one result item, laid out as m_axis_tdata_o
  typedef struct packed {
    logic [3:0]         pad;
    logic               is_empty;
    logic               is_full;
    logic [OCC_W-1:0]   occupancy;
    logic [LEN_W-1:0]   entry_length;
    logic [CHARS_W-1:0] entry_chars;
    logic [SLOT_W-1:0]  found_slot;
    logic               ok;
  } result_t;

  // mirror of the key table plus the queue of results still to come
  class key_table_model;
    logic [CHARS_W-1:0] keys [DEPTH];
    int unsigned        lens [DEPTH];
    int unsigned        count;
    int unsigned        cap;
    int unsigned        isz;
    result_t            pending_results[$];
    int unsigned        errors;
    int unsigned        checked;

    function new();
      count   = 0;
      cap     = CAP_RESET;
      isz     = ISZ_RESET;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_CAPACITY) cap = data[CAP_W-1:0];
      else if (idx == CFG_ITEM_SIZE) isz = data[ISZ_W-1:0];
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function bit is_full();
      int unsigned limit;
      limit = (cap > DEPTH) ? DEPTH : cap;
      return count >= limit;
    endfunction

    // effective key: bytes before the first zero within klen; 0 if klen too long
    function bit normalize(logic [CHARS_W-1:0] chars, logic [LEN_W-1:0] klen,
                           output logic [CHARS_W-1:0] val, output int unsigned n);
      bit stop;
      val  = '0;
      n    = 0;
      stop = 0;
      if (klen > NAME_BYTES) return 0;
      for (int i = 0; i < NAME_BYTES; i++) begin
        if (!stop && i < klen && chars[8*i +: 8] != 8'h00) begin
          val[8*i +: 8] = chars[8*i +: 8];
          n++;
        end else begin
          stop = 1;
        end
      end
      return 1;
    endfunction

    // first occupied slot holding the key, or -1
    function int lookup(logic [CHARS_W-1:0] val, int unsigned n);
      for (int i = 0; i < count; i++)
        if (lens[i] == n && keys[i] == val) return i;
      return -1;
    endfunction

    // update the mirror for an accepted item and queue its result
    function void apply_op(op_t op);
      result_t            r;
      logic [CHARS_W-1:0] v;
      int unsigned        n;
      int                 pos;
      r = '0;
      case (op.kind)
        KIND_APPEND: begin
          if (normalize(op.chars, op.klen, v, n) && n != 0 && n + 1 <= isz &&
              !is_full() && lookup(v, n) < 0 && count < DEPTH) begin
            keys[count] = v;
            lens[count] = n;
            count++;
            r.ok = 1'b1;
          end
        end
        KIND_REMOVE: begin
          if (op.slot < count) begin
            // last entry fills the hole
            if (op.slot != count - 1) begin
              keys[op.slot] = keys[count-1];
              lens[op.slot] = lens[count-1];
            end
            count--;
            r.ok = 1'b1;
          end
        end
        KIND_FETCH: begin
          if (normalize(op.chars, op.klen, v, n)) begin
            pos = lookup(v, n);
            if (pos >= 0) begin
              r.ok         = 1'b1;
              r.found_slot = pos[SLOT_W-1:0];
            end
          end
        end
        KIND_GET: begin
          if (op.slot < count) begin
            r.ok           = 1'b1;
            r.entry_chars  = keys[op.slot];
            r.entry_length = lens[op.slot][LEN_W-1:0];
          end
        end
        KIND_CLEAR: begin
          count = 0;
          r.ok  = 1'b1;
        end
        default: ;
      endcase
      r.occupancy = count[OCC_W-1:0];
      r.is_full   = is_full();
      r.is_empty  = (count == 0);
      pending_results.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch at result %0d: %s", checked, what);
      errors++;
    endtask

    // compare one accepted result with the oldest expectation
    task check_result(logic [OUT_TDATA_W-1:0] raw);
      result_t got;
      result_t want;
      got = raw;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %h", raw));
        return;
      end
      want = pending_results.pop_front();
      if (got.ok !== want.ok)
        report($sformatf("ok %b, expected %b", got.ok, want.ok));
      if (got.found_slot !== want.found_slot)
        report($sformatf("found_slot %0d, expected %0d", got.found_slot, want.found_slot));
      if (got.entry_chars !== want.entry_chars)
        report($sformatf("entry_chars %h, expected %h", got.entry_chars, want.entry_chars));
      if (got.entry_length !== want.entry_length)
        report($sformatf("entry_length %0d, expected %0d", got.entry_length,
                         want.entry_length));
      if (got.occupancy !== want.occupancy)
        report($sformatf("occupancy %0d, expected %0d", got.occupancy, want.occupancy));
      if (got.is_full !== want.is_full)
        report($sformatf("is_full %b, expected %b", got.is_full, want.is_full));
      if (got.is_empty !== want.is_empty)
        report($sformatf("is_empty %b, expected %b", got.is_empty, want.is_empty));
      checked++;
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_valid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [KIND_W-1:0]      s_tuser = '0;
  logic                   m_tready = 1'b0;
  logic                   c_valid = 1'b0;
  logic [CFG_IDX_W-1:0]   c_index = '0;
  logic [CFG_DATA_W-1:0]  c_data = '0;
  wire                    s_axis_tready_o;
  wire                    m_axis_tvalid_o;
  wire [OUT_TDATA_W-1:0]  m_axis_tdata_o;
  wire                    cfg_ready_o;

  key_table_model tbl = new();
  int unsigned    cycles = 0;
  int unsigned    tx_idle_pct = 16;
  int unsigned    rx_idle_pct = 73;
  int unsigned    random_sent = 0;

  bounded_string_set uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (c_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (c_index),
    .cfg_data_i      (c_data)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random backpressure and checking
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_tready) tbl.check_result(m_axis_tdata_o);
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic op_t make_item(logic [KIND_W-1:0] kind, logic [CHARS_W-1:0] chars,
                                    logic [LEN_W-1:0] klen, logic [SLOT_W-1:0] slot);
    op_t op;
    op.kind  = kind;
    op.chars = chars;
    op.klen  = klen;
    op.slot  = slot;
    return op;
  endfunction

  // present one item, optionally after idle cycles, and note it on acceptance
  task automatic send_op(op_t op);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= {6'b0, op.slot, op.klen, op.chars};
    s_tuser <= op.kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tbl.apply_op(op);
  endtask

  // stop sending and wait until every expected result has arrived
  task automatic drain();
    s_valid <= 1'b0;
    while (tbl.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    c_valid <= 1'b1;
    c_index <= idx;
    c_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tbl.set_register(idx, data);
  endtask

  task automatic configure(int unsigned cap, int unsigned isz);
    write_register(CFG_CAPACITY, CFG_DATA_W'(cap));
    write_register(CFG_ITEM_SIZE, CFG_DATA_W'(isz));
    c_valid <= 1'b0;
  endtask

  // key stimulus: stored keys with junk above, short fresh keys, raw noise
  task automatic make_key(output logic [CHARS_W-1:0] chars, output logic [LEN_W-1:0] klen);
    int unsigned        r;
    int unsigned        n;
    int unsigned        pick;
    logic [CHARS_W-1:0] junk;
    r    = $urandom_range(99);
    junk = {$urandom, $urandom};
    if (r < 40 && tbl.count != 0) begin
      pick  = $urandom_range(tbl.count - 1);
      n     = tbl.lens[pick];
      klen  = LEN_W'(n + $urandom_range(NAME_BYTES - n));
      chars = tbl.keys[pick];
      if (klen == n) chars = chars | (junk << (8 * n));
      else chars = chars | (junk << (8 * (n + 1)));
    end else if (r < 75) begin
      n     = $urandom_range(1, 4);
      chars = '0;
      for (int i = 0; i < n; i++) chars[8*i +: 8] = 8'h61 + 8'($urandom_range(3));
      case ($urandom_range(3))
        0, 1: klen = LEN_W'(n);
        2: begin
          // terminator inside the given length
          klen  = LEN_W'($urandom_range(n, NAME_BYTES));
          chars = chars | (junk << (8 * (n + 1)));
        end
        default: begin
          // length cuts the key short
          klen  = LEN_W'($urandom_range(n));
          chars = chars | (junk << (8 * n));
        end
      endcase
    end else if (r < 88) begin
      chars = junk;
      klen  = LEN_W'($urandom_range(NAME_BYTES));
    end else begin
      chars = junk;
      klen  = LEN_W'($urandom_range(15));
    end
  endtask

  task automatic random_op(int unsigned clear_pct, int unsigned append_pct);
    op_t         op;
    int unsigned r;
    make_key(op.chars, op.klen);
    if (tbl.count != 0 && $urandom_range(9) < 8)
      op.slot = SLOT_W'($urandom_range(tbl.count - 1));
    else
      op.slot = SLOT_W'($urandom_range(DEPTH - 1));
    r = $urandom_range(99);
    if ($urandom_range(99) < clear_pct) begin
      op.kind = KIND_CLEAR;
    end else if ($urandom_range(99) < append_pct) begin
      op.kind = KIND_APPEND;
    end else if (r < 35) begin
      op.kind = KIND_FETCH;
    end else if (r < 60) begin
      op.kind = KIND_GET;
    end else if (r < 95) begin
      op.kind = KIND_REMOVE;
    end else begin
      op.kind = KIND_W'($urandom_range(int'(KIND_CLEAR) + 1, KIND_CODES - 1));
    end
    send_op(op);
  endtask

  // one setting of the registers followed by random items
  task automatic run_phase(int unsigned cap, int unsigned isz, int unsigned n_items,
                           int unsigned clear_pct, int unsigned append_pct);
    drain();
    configure(cap, isz);
    for (int i = 0; i < n_items; i++) begin
      // idle profile moves on by thirds of the random part
      if (random_sent < 493) begin
        tx_idle_pct = 16;
        rx_idle_pct = 73;
      end else if (random_sent < 987) begin
        tx_idle_pct = 73;
        rx_idle_pct = 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_op(clear_pct, append_pct);
      random_sent++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset setting: capacity 64, item size 9
    send_op(make_item(KIND_APPEND, 64'h61, 4'd1, '0));
    send_op(make_item(KIND_APPEND, '0, 4'd0, '0));
    send_op(make_item(KIND_APPEND, 64'h0063_6200, 4'd3, '0));
    send_op(make_item(KIND_APPEND, '1, 4'd8, '0));
    send_op(make_item(KIND_APPEND, 64'h6867_6665_6463_6261, 4'd9, '0));
    send_op(make_item(KIND_APPEND, 64'h6867_6665_6463_6261, 4'd15, '0));
    send_op(make_item(KIND_APPEND, 64'hA5A5_A5A5_A5A5_A561, 4'd1, '0));
    send_op(make_item(KIND_APPEND, 64'h5A5A_5A5A_5A00_6261, 4'd6, '0));
    send_op(make_item(KIND_FETCH, 64'h1234_5678_9ABC_DE61, 4'd1, '0));
    send_op(make_item(KIND_FETCH, '1, 4'd8, '0));
    send_op(make_item(KIND_FETCH, 64'h6261, 4'd15, '0));
    send_op(make_item(KIND_FETCH, 64'h7A7A, 4'd2, '0));
    send_op(make_item(KIND_FETCH, '0, 4'd0, '0));
    send_op(make_item(KIND_GET, '0, 4'd0, 6'd0));
    send_op(make_item(KIND_GET, '0, 4'd0, 6'd2));
    send_op(make_item(KIND_GET, '1, 4'd15, 6'd3));
    send_op(make_item(KIND_GET, '0, 4'd0, 6'd63));
    send_op(make_item(KIND_REMOVE, '0, 4'd0, 6'd0));
    send_op(make_item(KIND_GET, '0, 4'd0, 6'd0));
    send_op(make_item(KIND_REMOVE, '0, 4'd0, 6'd5));
    for (int k = int'(KIND_CLEAR) + 1; k < KIND_CODES; k++)
      send_op(make_item(KIND_W'(k), '1, 4'd1, 6'd0));
    send_op(make_item(KIND_CLEAR, '0, 4'd0, '0));
    send_op(make_item(KIND_GET, '0, 4'd0, 6'd0));
    send_op(make_item(KIND_REMOVE, '0, 4'd0, 6'd0));

    // random part: capacity, item size, items, clear and append weights
    run_phase(4, 4, 150, 3, 50);
    run_phase(1, 9, 80, 3, 50);
    run_phase(64, 9, 400, 0, 80);
    // capacity below the current occupancy
    run_phase(10, 2, 100, 2, 45);
    // capacity saturates, item size zero rejects every append
    run_phase(127, 0, 100, 0, 50);
    run_phase(100, 15, 200, 0, 70);
    run_phase(0, 9, 50, 0, 50);
    run_phase(16, 5, 300, 3, 55);
    run_phase(2, 1, 100, 5, 50);

    drain();
    repeat (TAIL) @(posedge clk_i);
    if (tbl.pending() != 0) tbl.report($sformatf("%0d results missing", tbl.pending()));
    if (tbl.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
